/* design/wfs_pkg.sv */
package wfs_pkg;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] CFG_REVERSE  = 3'd0;
	localparam logic [2:0] CFG_FWD      = 3'd1;
	localparam logic [2:0] CFG_SIDE     = 3'd2;
	localparam logic [2:0] CFG_DEADBAND = 3'd3;
	localparam logic [2:0] CFG_LOOKBACK = 3'd4;
	localparam logic [2:0] CFG_ARR_BASE = 3'd5;
	localparam logic [2:0] CFG_ARR_SLOPE = 3'd6;

	localparam int ATAN_LEN = 24;
	localparam logic [16:0] INV_GAIN = 17'd39797;
	localparam logic signed [15:0] SPEED_LIM = 16'sd8000;

	// Arctangent table in binary-angle units
	function automatic logic [13:0] atan_lut(input logic [4:0] i);
		logic [13:0] r;
		begin
			unique case (i)
				5'd0: r = 14'd8192;
				5'd1: r = 14'd4836;
				5'd2: r = 14'd2555;
				5'd3: r = 14'd1297;
				5'd4: r = 14'd651;
				5'd5: r = 14'd326;
				5'd6: r = 14'd163;
				5'd7: r = 14'd81;
				5'd8: r = 14'd41;
				5'd9: r = 14'd20;
				5'd10: r = 14'd10;
				5'd11: r = 14'd5;
				5'd12: r = 14'd3;
				5'd13: r = 14'd1;
				5'd14: r = 14'd1;
				default: r = 14'd0;
			endcase
			return r;
		end
	endfunction

endpackage

/* design/waypoint_follow_steering.sv */
// Waypoint follower. A load writes one waypoint into the path memory. A pose
// tick scans the stored path through the single memory read port, one waypoint
// a cycle, reads the target entry, then runs two vectoring CORDICs on one
// shared iterative unit, each followed by two short steps, ST_MUL and ST_RAD,
// then a decision state. Only one item is in work at a time; the result sits
// in an output register so the next item is accepted while it waits, and a
// later tick holds in its decision state until that result has been taken.
// Ticks on an empty or finished path give no result. There is no clearing
// pass after reset.
module waypoint_follow_steering import wfs_pkg::*; #(
	parameter int MAX_POINTS   = 256,
	parameter int CORDIC_ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [7:0]         point_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [15:0]        heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] left_speed,
	output logic signed [13:0] right_speed,
	output logic               arrived,
	output logic [7:0]         target_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = AW + 1;
	localparam int IW = $clog2(CORDIC_ITERS + 1);
	localparam int NIT = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_TRD   = 4'd2;
	localparam logic [3:0] ST_TGET  = 4'd3;
	localparam logic [3:0] ST_COR   = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_RAD   = 4'd6;
	localparam logic [3:0] ST_DEC   = 4'd7;

	// Configuration registers
	logic        rev_q;
	logic [11:0] fwd_q, side_q;
	logic [14:0] dband_q;
	logic [7:0]  lookb_q;
	logic [15:0] abase_q, aslope_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q    <= 1'b0;
			fwd_q    <= 12'd350;
			side_q   <= 12'd50;
			dband_q  <= 15'd521;
			lookb_q  <= 8'd5;
			abase_q  <= 16'd410;
			aslope_q <= 16'd2621;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REVERSE:   rev_q    <= cfg_data[0];
				CFG_FWD:       fwd_q    <= cfg_data[11:0];
				CFG_SIDE:      side_q   <= cfg_data[11:0];
				CFG_DEADBAND:  dband_q  <= cfg_data[14:0];
				CFG_LOOKBACK:  lookb_q  <= cfg_data[7:0];
				CFG_ARR_BASE:  abase_q  <= cfg_data;
				CFG_ARR_SLOPE: aslope_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Path memory, one write and one registered read port
	logic [47:0]   mem [MAX_POINTS];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [47:0]   mem_rd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= {pos_x, pos_y};
		mem_rd <= mem[mem_ra];
	end

	logic [3:0]      st_q;
	logic [CW-1:0]   count_q;
	logic            fin_q;
	logic [CW-1:0]   rd_q;       // next read address during scan
	logic [CW-1:0]   cmp_q;      // index of entry in mem_rd
	logic            rdv_q;
	logic [48:0]     best_q;
	logic [AW-1:0]   near_q;
	logic signed [23:0] px_q, py_q;
	logic [15:0]     head_q;
	logic [AW-1:0]   tgt_q;
	logic signed [23:0] gx_q, gy_q;
	logic            pass_q;     // 0: robot-to-goal, 1: goal norm
	logic [IW-1:0]   it_q;
	logic signed [27:0] cx_q, cy_q;
	logic signed [17:0] cz_q;
	logic [15:0]     bear_q;
	logic [26:0]     dist_q;
	logic [43:0]     prod_q;
	logic            res_v_q;
	logic signed [13:0] l_q, r_q;
	logic            arr_q;
	logic [7:0]      ti_q;

	logic in_xfer;
	logic dec_go;
	assign in_ready = (st_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// decision cycle may finish once the output register is free or being taken
	assign dec_go   = (st_q == ST_DEC) && (!res_v_q || out_ready);
	assign out_valid    = res_v_q;
	assign left_speed   = l_q;
	assign right_speed  = r_q;
	assign arrived      = arr_q;
	assign target_index = ti_q;

	// Squared distance of the entry being compared
	logic signed [24:0] ddx, ddy;
	logic [48:0] dsq;
	assign ddx = 25'(signed'(mem_rd[47:24])) - 25'(px_q);
	assign ddy = 25'(signed'(mem_rd[23:0])) - 25'(py_q);
	assign dsq = 49'(ddx * ddx) + 49'(ddy * ddy);

	assign mem_we = in_xfer && req_type == REQ_LOAD && 32'(point_index) < MAX_POINTS;
	assign mem_wa = AW'(point_index);
	always_comb begin
		mem_ra = rd_q[AW-1:0];
		if (st_q == ST_TRD) mem_ra = tgt_q;
	end

	// CORDIC step
	logic signed [27:0] xs, ys;
	logic [13:0] at;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = atan_lut(5'(it_q));

	// Load of a new CORDIC vector
	logic signed [24:0] vx, vy;
	always_comb begin
		if (!pass_q) begin
			vx = 25'(gx_q) - 25'(px_q);
			vy = 25'(gy_q) - 25'(py_q);
		end else begin
			vx = 25'(gx_q);
			vy = 25'(gy_q);
		end
	end

	// Steering decision
	logic signed [15:0] err;
	logic signed [14:0] lf, rf;
	logic signed [15:0] lw, rw;
	always_comb begin
		err = signed'(bear_q - head_q);
		if ($signed(17'(err)) < -$signed(17'({2'b0, dband_q}))) begin
			lf = 15'(fwd_q) + 15'(side_q);
			rf = 15'(fwd_q) - 15'(side_q);
		end else if ($signed(17'(err)) > $signed(17'({2'b0, dband_q}))) begin
			lf = 15'(fwd_q) - 15'(side_q);
			rf = 15'(fwd_q) + 15'(side_q);
		end else begin
			lf = 15'(fwd_q);
			rf = 15'(fwd_q);
		end
		if (rev_q) begin
			lw = -16'(rf);
			rw = -16'(lf);
		end else begin
			lw = 16'(lf);
			rw = 16'(rf);
		end
		if (lw > SPEED_LIM) lw = SPEED_LIM;
		if (lw < -SPEED_LIM) lw = -SPEED_LIM;
		if (rw > SPEED_LIM) rw = SPEED_LIM;
		if (rw < -SPEED_LIM) rw = -SPEED_LIM;
	end

	logic [AW:0] lb_diff;
	assign lb_diff = (AW+1)'(near_q) - (AW+1)'(lookb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			fin_q   <= 1'b0;
			res_v_q <= 1'b0;
			rdv_q   <= 1'b0;
		end else begin
			// result register: filled by the decision, emptied by a transfer
			if (dec_go) res_v_q <= 1'b1;
			else if (out_valid && out_ready) res_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (req_type == REQ_LOAD) begin
							if (mem_we) begin
								count_q <= CW'(point_index) + CW'(1);
								fin_q   <= 1'b0;
							end
						end else if (!fin_q && count_q != '0) begin
							px_q   <= pos_x;
							py_q   <= pos_y;
							head_q <= rev_q ? heading + 16'h8000 : heading;
							rd_q   <= '0;
							rdv_q  <= 1'b0;
							st_q   <= ST_SCAN;
						end
					end
				end
				// One entry read per cycle, compared in the next cycle
				ST_SCAN: begin
					rdv_q <= rd_q < count_q;
					cmp_q <= rd_q;
					if (rd_q < count_q) rd_q <= rd_q + CW'(1);
					if (rdv_q) begin
						if (cmp_q == '0 || dsq < best_q) begin
							best_q <= dsq;
							near_q <= cmp_q[AW-1:0];
						end
					end
					if (!rdv_q && rd_q == count_q) st_q <= ST_TRD;
				end
				ST_TRD: begin
					st_q <= ST_TGET;
				end
				ST_TGET: begin
					gx_q  <= signed'(mem_rd[47:24]);
					gy_q  <= signed'(mem_rd[23:0]);
					pass_q <= 1'b0;
					it_q  <= IW'(NIT);
					st_q  <= ST_COR;
				end
				ST_COR: begin
					if (it_q == IW'(NIT)) begin
						// pre-rotate left half plane
						if (vx < 0) begin
							cx_q <= -28'(vx);
							cy_q <= -28'(vy);
							cz_q <= 18'sd32768;
						end else begin
							cx_q <= 28'(vx);
							cy_q <= 28'(vy);
							cz_q <= '0;
						end
						it_q <= '0;
					end else begin
						if (cy_q > 0) begin
							cx_q <= cx_q + ys;
							cy_q <= cy_q - xs;
							cz_q <= cz_q + 18'(at);
						end else begin
							cx_q <= cx_q - ys;
							cy_q <= cy_q + xs;
							cz_q <= cz_q - 18'(at);
						end
						if (it_q == IW'(NIT - 1)) st_q <= ST_MUL;
						else it_q <= it_q + IW'(1);
					end
				end
				ST_MUL: begin
					if (!pass_q) bear_q <= cz_q[15:0];
					prod_q <= (cx_q < 0) ? '0 : 44'(cx_q[26:0]) * 44'(INV_GAIN);
					st_q <= ST_RAD;
				end
				ST_RAD: begin
					if (!pass_q) begin
						dist_q <= prod_q[42:16];
						pass_q <= 1'b1;
						it_q   <= IW'(NIT);
						st_q   <= ST_COR;
					end else begin
						prod_q  <= 44'(aslope_q) * 44'(prod_q[42:16]);
						st_q    <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (dec_go) begin
						ti_q <= 8'(tgt_q);
						if (28'(dist_q) < 28'(abase_q) + 28'(prod_q[43:16])) begin
							fin_q <= 1'b1;
							l_q   <= '0;
							r_q   <= '0;
							arr_q <= 1'b1;
						end else begin
							l_q   <= lw[13:0];
							r_q   <= rw[13:0];
							arr_q <= 1'b0;
						end
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// target index once the scan ends
			if (st_q == ST_SCAN && !rdv_q && rd_q == count_q)
				tgt_q <= lb_diff[AW] || lb_diff == '0 ? '0 : lb_diff[AW-1:0];
		end
	end

endmodule
